>>> rtl/skf_pkg.sv
// shared widths, formats and register indexes for the scalar kalman filter
// no dependencies; imported by every module of the block
package skf_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // gain is unsigned q0.F with one extra bit so that one is representable
   localparam int GAIN_W   = FRAC_BITS + 1;
   // multiplicand: magnitude of a signed difference or an unsigned covariance
   localparam int MUL_A_W  = DATA_WIDTH + 1;
   localparam int PROD_W   = MUL_A_W + GAIN_W;
   // denominator p1 + r is kept exact
   localparam int DEN_W    = DATA_WIDTH + 1;
   localparam int REM_W    = DATA_WIDTH + 2;
   // both serial units run one step per gain bit
   localparam int STEPS    = GAIN_W;
   localparam int CNT_W    = $clog2(STEPS);

   localparam int REQ_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_WIDTH + GAIN_W + 7) / 8) * 8;

   localparam int CSR_IDX_W = 2;

   localparam logic [GAIN_W-1:0]     ONE_GAIN = GAIN_W'(1) << FRAC_BITS;
   localparam logic [DATA_WIDTH-1:0] ONE_FX   = DATA_WIDTH'(1) << FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_ESTIMATE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_ERROR_COV = 2'd3;

   // handshake between the sequencer and a serial unit
   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage

>>> rtl/skf_div.sv
// bit-serial restoring divider for the kalman gain: num * 2^F / den, num <= den
// one quotient bit per cycle; depends on skf_pkg
module skf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [skf_pkg::DATA_WIDTH-1:0] num,
   input  logic [skf_pkg::DEN_W-1:0]      den,
   output logic                           done,
   output logic [skf_pkg::GAIN_W-1:0]     quotient
);
   import skf_pkg::*;

   logic [REM_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [GAIN_W-1:0] quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [REM_W-1:0]  trial;
   logic              fits;

   // first step compares without shifting, the rest shift one bit in
   assign trial = (cnt_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign fits  = trial >= REM_W'(den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= REM_W'(num);
         den_ff <= den;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - REM_W'(den_ff)) : trial;
         quo_ff <= {quo_ff[GAIN_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/skf_mul.sv
// serial shift-add multiplier: one bit of the gain operand per cycle, lsb first
// depends on skf_pkg
module skf_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [skf_pkg::MUL_A_W-1:0] a,
   input  logic [skf_pkg::GAIN_W-1:0]  b,
   output logic                        done,
   output logic [skf_pkg::PROD_W-1:0]  product
);
   import skf_pkg::*;

   logic [MUL_A_W-1:0] a_ff;
   logic [GAIN_W-1:0]  b_ff;
   logic [MUL_A_W-1:0] hi_ff;
   logic [GAIN_W-1:0]  lo_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [MUL_A_W:0]   sum;

   assign sum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // accumulator shifts right, retired low bits move into lo_ff
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         b_ff  <= b;
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (busy_ff) begin
         hi_ff <= sum[MUL_A_W:1];
         lo_ff <= {sum[0], lo_ff[GAIN_W-1:1]};
         b_ff  <= {1'b0, b_ff[GAIN_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

>>> rtl/scalar_kalman_filter_unit.sv
// scalar kalman filter top level: config registers, filter state and sequencer
// uses skf_pkg, skf_div and skf_mul
//
// usage:
//   req channel carries one sample per item: req_tdata holds the signed q16.16
//   measurement, req_tuser the restart flag that reloads estimate and error
//   covariance from init_estimate / init_error_cov before the update.
//   rsp channel returns one item per sample: new estimate and the gain used.
//   csr port writes process_noise, meas_noise, init_estimate, init_error_cov
//   by index; write only while no sample is in flight.
// timing:
//   one item at a time. the time from accept to result is set by the serial
//   divider and two passes through the shared serial multiplier, plus the
//   sequencing states. req_tready is high again once the result sits in
//   the output register, so the next sample is taken while the receiver
//   holds off.
// reset:
//   synchronous; estimate goes to 0, covariance and meas_noise to one,
//   process_noise and init_estimate to 0, init_error_cov to one.
// stall:
//   a result waits in the output register until rsp_tready; a finished
//   item behind it waits in the sequencer without loss.
module scalar_kalman_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   // measurement
   input  logic [skf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // restart
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // estimate_out, gain_out, zero fill
   output logic [skf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wen,
   input  logic [skf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [skf_pkg::DATA_WIDTH-1:0]    csr_wdata
);
   import skf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EST_GO,
      ST_EST_MUL,
      ST_COV_GO,
      ST_COV_MUL,
      ST_SEND
   } state_type;

   state_type state_ff;

   logic [DATA_WIDTH-1:0] process_noise_ff;
   logic [DATA_WIDTH-1:0] meas_noise_ff;
   logic [DATA_WIDTH-1:0] init_estimate_ff;
   logic [DATA_WIDTH-1:0] init_error_cov_ff;

   logic [DATA_WIDTH-1:0] estimate_ff;
   logic [DATA_WIDTH-1:0] error_cov_ff;

   logic [DATA_WIDTH-1:0] meas_ff;
   logic [DATA_WIDTH-1:0] p1_ff;
   logic                  den_zero_ff;
   logic                  diff_neg_ff;
   logic [MUL_A_W-1:0]    diff_mag_ff;
   logic [GAIN_W-1:0]     gain_ff;

   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   rsp_valid_ff;

   logic                  accept;
   logic                  rsp_load;
   logic [DATA_WIDTH-1:0] cov_src;
   logic [DATA_WIDTH:0]   cov_sum;
   logic [DATA_WIDTH-1:0] p1_in;
   logic [DEN_W-1:0]      den;
   logic [MUL_A_W:0]      diff;
   logic [MUL_A_W-1:0]    mul_a;
   logic [GAIN_W-1:0]     mul_b;
   logic [MUL_A_W:0]      scaled;
   logic [MUL_A_W:0]      est_wide;

   unit_ctl_type          div_ctl;
   unit_ctl_type          mul_ctl;
   logic [GAIN_W-1:0]     div_quo;
   logic [PROD_W-1:0]     mul_prod;

   assign accept   = req_tvalid && req_tready;
   assign rsp_load = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_tready);

   // predict step: p + q saturating
   assign cov_src = req_tuser ? init_error_cov_ff : error_cov_ff;
   assign cov_sum = {1'b0, cov_src} + {1'b0, process_noise_ff};
   assign p1_in   = cov_sum[DATA_WIDTH] ? '1 : cov_sum[DATA_WIDTH-1:0];

   assign den  = {1'b0, p1_ff} + {1'b0, meas_noise_ff};
   assign diff = {{2{meas_ff[DATA_WIDTH-1]}}, meas_ff}
               - {{2{estimate_ff[DATA_WIDTH-1]}}, estimate_ff};

   assign div_ctl.start = (state_ff == ST_PREP);
   assign mul_ctl.start = (state_ff == ST_EST_GO) || (state_ff == ST_COV_GO);

   assign mul_a = (state_ff == ST_EST_GO) ? diff_mag_ff : {1'b0, p1_ff};
   assign mul_b = (state_ff == ST_EST_GO) ? gain_ff : (ONE_GAIN - gain_ff);

   // correction is truncated toward zero on the magnitude, then signed
   assign scaled   = {1'b0, mul_prod[FRAC_BITS +: MUL_A_W]};
   assign est_wide = diff_neg_ff
                   ? ({estimate_ff[DATA_WIDTH-1], estimate_ff[DATA_WIDTH-1], estimate_ff}
                      - scaled)
                   : ({estimate_ff[DATA_WIDTH-1], estimate_ff[DATA_WIDTH-1], estimate_ff}
                      + scaled);

   skf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .num      (p1_ff),
      .den      (den),
      .done     (div_ctl.done),
      .quotient (div_quo)
   );

   skf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_ctl.start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_ctl.done),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff  <= '0;
         meas_noise_ff     <= ONE_FX;
         init_estimate_ff  <= '0;
         init_error_cov_ff <= ONE_FX;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PROCESS_NOISE:  process_noise_ff  <= csr_wdata;
            CSR_MEAS_NOISE:     meas_noise_ff     <= csr_wdata;
            CSR_INIT_ESTIMATE:  init_estimate_ff  <= csr_wdata;
            CSR_INIT_ERROR_COV: init_error_cov_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         estimate_ff  <= '0;
         error_cov_ff <= ONE_FX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser) begin
                     estimate_ff <= init_estimate_ff;
                  end
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_ctl.done) begin
                  state_ff <= ST_EST_GO;
               end
            end
            ST_EST_GO: begin
               state_ff <= ST_EST_MUL;
            end
            ST_EST_MUL: begin
               if (mul_ctl.done) begin
                  estimate_ff <= est_wide[DATA_WIDTH-1:0];
                  state_ff    <= ST_COV_GO;
               end
            end
            ST_COV_GO: begin
               state_ff <= ST_COV_MUL;
            end
            ST_COV_MUL: begin
               if (mul_ctl.done) begin
                  error_cov_ff <= mul_prod[FRAC_BITS +: DATA_WIDTH];
                  state_ff     <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // working values, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         meas_ff <= req_tdata[DATA_WIDTH-1:0];
         p1_ff   <= p1_in;
      end
      if (state_ff == ST_PREP) begin
         den_zero_ff <= (den == '0);
         diff_neg_ff <= diff[MUL_A_W];
         diff_mag_ff <= diff[MUL_A_W] ? MUL_A_W'(-diff) : diff[MUL_A_W-1:0];
      end
      if ((state_ff == ST_DIV) && div_ctl.done) begin
         gain_ff <= den_zero_ff ? '0 : div_quo;
      end
      if (rsp_load) begin
         rsp_data_ff <= RSP_TDATA_W'({gain_ff, estimate_ff});
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
